FILE: src/prq_pkg.sv
// shared types, codes and defaults of the priority ready queue
package prq_pkg;

	// default number of queue slots
	localparam int PRQ_DEPTH = 16;

	// payload widths
	localparam int ID_W   = 8;
	localparam int PRI_W  = 8;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	// request function codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

	// one queue slot
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
	} prq_entry_t;

	// finished request from the sequencer to the output register
	typedef struct packed {
		logic              fire;
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   id;
		logic [PRI_W-1:0]  pri;
		logic [OCC_W-1:0]  occ;
	} prq_done_t;

endpackage

FILE: src/priority_ready_queue_core.sv
// priority ready queue: top level with the result register
// sequence: a refused request goes straight to its result, a remove reads the head and
//   moves the rest forward, an insert searches, moves the tail back as needed and writes the entry
// throughput: one request at a time; the slot memory's single read and write port,
//   one entry per cycle, sets the figure; the next request is taken while a result waits
// reset: arst_n empties the queue at once; slot contents are not cleared
module priority_ready_queue_core #(
	parameter int DEPTH = prq_pkg::PRQ_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [prq_pkg::ID_W-1:0]    proc_id,
	input  logic [prq_pkg::PRI_W-1:0]   priority_req,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [prq_pkg::STAT_W-1:0]  status,
	output logic [prq_pkg::ID_W-1:0]    out_id,
	output logic [prq_pkg::PRI_W-1:0]   out_priority,
	output logic [prq_pkg::OCC_W-1:0]   occupancy
);
	import prq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic       busy;
	logic       out_free;
	prq_done_t  done;
	logic       mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	prq_entry_t mem_wdata;
	prq_entry_t mem_rdata;
	logic       out_valid_q;
	prq_done_t  res_q;

	prq_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	prq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.func         (func),
		.proc_id      (proc_id),
		.priority_req (priority_req),
		.busy         (busy),
		.out_free     (out_free),
		.done         (done),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	// request side stalls while the sequencer works
	assign in_stall = busy;

	// result register frees when empty or when its result is taken
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done.fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (done.fire) begin
			res_q <= done;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign out_id       = res_q.id;
	assign out_priority = res_q.pri;
	assign occupancy    = res_q.occ;

endmodule

FILE: src/prq_store.sv
// slot memory of the queue, one write port and one registered read port
module prq_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  prq_pkg::prq_entry_t wdata,
	input  logic [AW-1:0]       raddr,
	output prq_pkg::prq_entry_t rdata
);
	import prq_pkg::*;

	prq_entry_t mem_q [DEPTH];
	prq_entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/prq_ctrl.sv
// sequencer that searches and shifts the slot memory one entry per cycle
module prq_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int CW    = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         func,
	input  logic [prq_pkg::ID_W-1:0]     proc_id,
	input  logic [prq_pkg::PRI_W-1:0]    priority_req,
	output logic                         busy,
	input  logic                         out_free,
	output prq_pkg::prq_done_t           done,
	output logic                         mem_we,
	output logic [AW-1:0]                mem_waddr,
	output prq_pkg::prq_entry_t          mem_wdata,
	output logic [AW-1:0]                mem_raddr,
	input  prq_pkg::prq_entry_t          mem_rdata
);
	import prq_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCAN  = 7'b0000010,
		ST_SHIFT = 7'b0000100,
		ST_PUT   = 7'b0001000,
		ST_HEAD  = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     k_q, k_d;
	logic [CW-1:0]     pos_q, pos_d;
	prq_entry_t        new_q, new_d;
	logic [STAT_W-1:0] status_q, status_d;
	prq_entry_t        head_q, head_d;
	logic              fire;

	// sequencer: one memory read and at most one write per cycle
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		k_d       = k_q;
		pos_d     = pos_q;
		new_d     = new_q;
		status_d  = status_q;
		head_d    = head_q;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = new_q;
		fire      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					new_d    = '{id: proc_id, pri: priority_req};
					status_d = STATUS_DONE;
					head_d   = '0;
					k_d      = '0;
					if (func == FUNC_INSERT) begin
						if (count_q == CW'(DEPTH)) begin
							status_d = STATUS_FULL;
							state_d  = ST_DONE;
						end else if (count_q == '0) begin
							pos_d   = '0;
							state_d = ST_PUT;
						end else begin
							state_d = ST_SCAN;
						end
					end else begin
						if (count_q == '0) begin
							status_d = STATUS_EMPTY;
							state_d  = ST_DONE;
						end else begin
							state_d = ST_HEAD;
						end
					end
				end
			end
			ST_SCAN: begin
				// first slot of strictly lower priority takes the new entry
				if (mem_rdata.pri < new_q.pri) begin
					pos_d     = k_q;
					k_d       = count_q;
					mem_raddr = AW'(count_q - 1'b1);
					state_d   = ST_SHIFT;
				end else if (k_q + 1'b1 == count_q) begin
					pos_d   = count_q;
					state_d = ST_PUT;
				end else begin
					k_d       = k_q + 1'b1;
					mem_raddr = AW'(k_q + 1'b1);
				end
			end
			ST_SHIFT: begin
				// move the tail back by one slot, last entry first
				mem_we    = 1'b1;
				mem_waddr = AW'(k_q);
				mem_wdata = mem_rdata;
				if (k_q - 1'b1 == pos_q) begin
					state_d = ST_PUT;
				end else begin
					k_d       = k_q - 1'b1;
					mem_raddr = AW'(k_q - 2'd2);
				end
			end
			ST_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(pos_q);
				mem_wdata = new_q;
				count_d   = count_q + 1'b1;
				state_d   = ST_DONE;
			end
			ST_HEAD: begin
				head_d = mem_rdata;
				if (count_q == CW'(1)) begin
					count_d = count_q - 1'b1;
					state_d = ST_DONE;
				end else begin
					k_d       = '0;
					mem_raddr = AW'(1);
					state_d   = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// move every remaining entry forward by one slot
				mem_we    = 1'b1;
				mem_waddr = AW'(k_q);
				mem_wdata = mem_rdata;
				if (k_q + 2'd2 == count_q) begin
					count_d = count_q - 1'b1;
					state_d = ST_DONE;
				end else begin
					k_d       = k_q + 1'b1;
					mem_raddr = AW'(k_q + 2'd2);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					fire    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		k_q      <= k_d;
		pos_q    <= pos_d;
		new_q    <= new_d;
		status_q <= status_d;
		head_q   <= head_d;
	end

	assign busy = (state_q != ST_IDLE);

	// finished request
	always_comb begin
		done.fire   = fire;
		done.status = status_q;
		done.id     = head_q.id;
		done.pri    = head_q.pri;
		done.occ    = OCC_W'(count_q);
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("held count above depth");

	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ({1'b0, mem_waddr} < (AW + 1)'(DEPTH)))
		else $error("slot write beyond depth");

	a_full_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && status_q == STATUS_FULL) |-> (count_q == CW'(DEPTH)))
		else $error("insert refused while queue not full");

	a_empty_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && status_q == STATUS_EMPTY) |-> (count_q == '0))
		else $error("remove refused while queue not empty");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1
			|| count_q + 1'b1 == $past(count_q)))
		else $error("held count moved by more than one");
`endif

endmodule
